// ===== hw/rtl/pwmsv_pkg.sv =====
// Shared types and constants for the PWM to stepper valve positioner.
// Used by every RTL module of the block; depends on nothing.
package pwmsv_pkg;

    localparam int MAX_STEPS_W   = 7;
    localparam int HALF_PERIOD_W = 16;
    localparam int PWM_W         = 8;
    localparam int POS_W         = 8;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [MAX_STEPS_W-1:0]   MAX_STEPS_RST   = 7'd50;
    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 16'd800;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic REG_MAX_STEPS   = 1'b0;
    localparam logic REG_HALF_PERIOD = 1'b1;

    typedef logic signed [POS_W-1:0] t_pos;

    typedef struct packed {
        logic step_level;
        logic dir_level;
        t_pos position;
        logic busy_res;
        logic accepted;
    } t_result;

endpackage

// ===== hw/rtl/pwm_to_stepper_valve_positioner.sv =====
// An accepted input transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle while results are taken; the move state updates with each one.
// The input register advances whenever it is empty or the result register is empty or being taken.
// Reset (synchronous, active low) clears position, target, timer and levels to zero,
// empties both registers, and loads max_steps = 50 and half_period_ticks = 800.
// Top level; depends on pwmsv_pkg, pwmsv_target and pwmsv_motion.
module pwm_to_stepper_valve_positioner (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_op,
    input  logic [pwmsv_pkg::PWM_W-1:0]          i_pwm_heat,
    input  logic [pwmsv_pkg::PWM_W-1:0]          i_pwm_cold,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_step_level,
    output logic                                 o_dir_level,
    output logic signed [pwmsv_pkg::POS_W-1:0]   o_position,
    output logic                                 o_busy_res,
    output logic                                 o_accepted,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pwmsv_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pwmsv_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pwmsv_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    logic [pwmsv_pkg::MAX_STEPS_W-1:0]    r_max_steps;
    logic [pwmsv_pkg::HALF_PERIOD_W-1:0]  r_half_period;
    logic                                 cfg_wr;

    logic                                 r_in_valid;
    logic                                 r_in_op;
    logic [pwmsv_pkg::PWM_W-1:0]          r_in_heat;
    logic [pwmsv_pkg::PWM_W-1:0]          r_in_cold;
    logic                                 r_out_valid;
    pwmsv_pkg::t_result                   r_out;
    pwmsv_pkg::t_result                   n_result;
    pwmsv_pkg::t_pos                      target;
    logic                                 advance;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_steps   <= pwmsv_pkg::MAX_STEPS_RST;
            r_half_period <= pwmsv_pkg::HALF_PERIOD_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                pwmsv_pkg::REG_MAX_STEPS: begin
                    r_max_steps <= pwdata[pwmsv_pkg::MAX_STEPS_W-1:0];
                end
                pwmsv_pkg::REG_HALF_PERIOD: begin
                    r_half_period <= pwdata[pwmsv_pkg::HALF_PERIOD_W-1:0];
                end
                default: begin
                    r_max_steps <= r_max_steps;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            pwmsv_pkg::REG_MAX_STEPS:   prdata = {25'd0, r_max_steps};
            pwmsv_pkg::REG_HALF_PERIOD: prdata = {16'd0, r_half_period};
            default:                    prdata = '0;
        endcase
    end

    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_op   <= i_op;
            r_in_heat <= i_pwm_heat;
            r_in_cold <= i_pwm_cold;
        end
    end

    pwmsv_target u_target (
        .i_pwm_heat  (r_in_heat),
        .i_pwm_cold  (r_in_cold),
        .i_max_steps (r_max_steps),
        .o_target    (target)
    );

    pwmsv_motion u_motion (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance && r_in_valid),
        .i_op          (r_in_op),
        .i_target      (target),
        .i_half_period (r_half_period),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= n_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_step_level = r_out.step_level;
    assign o_dir_level  = r_out.dir_level;
    assign o_position   = r_out.position;
    assign o_busy_res   = r_out.busy_res;
    assign o_accepted   = r_out.accepted;

endmodule

// ===== hw/rtl/pwmsv_target.sv =====
// Target computation: scales one PWM duty by max_steps and divides by 255.
// Depends on pwmsv_pkg.
module pwmsv_target (
    input  logic [pwmsv_pkg::PWM_W-1:0]       i_pwm_heat,
    input  logic [pwmsv_pkg::PWM_W-1:0]       i_pwm_cold,
    input  logic [pwmsv_pkg::MAX_STEPS_W-1:0] i_max_steps,
    output pwmsv_pkg::t_pos                   o_target
);

    logic                                                heat_only;
    logic                                                cold_only;
    logic [pwmsv_pkg::PWM_W-1:0]                         duty;
    logic [pwmsv_pkg::PWM_W+pwmsv_pkg::MAX_STEPS_W-1:0]  product;
    logic [pwmsv_pkg::PWM_W+pwmsv_pkg::MAX_STEPS_W:0]    sum;
    logic [pwmsv_pkg::MAX_STEPS_W-1:0]                   mag;
    pwmsv_pkg::t_pos                                     mag_s;

    assign heat_only = (i_pwm_heat != '0) && (i_pwm_cold == '0);
    assign cold_only = (i_pwm_cold != '0) && (i_pwm_heat == '0);
    assign duty      = heat_only ? i_pwm_heat : i_pwm_cold;
    assign product   = duty * i_max_steps;

    // Exact floor division by 255 for every product that the duty and max_steps can give (at most 255 * 127).
    assign sum   = {1'b0, product} + 16'd1 + {8'd0, product[14:8]};
    assign mag   = sum[14:8];
    assign mag_s = $signed({1'b0, mag});

    always_comb begin
        if (heat_only) begin
            o_target = mag_s;
        end else if (cold_only) begin
            o_target = -mag_s;
        end else begin
            o_target = '0;
        end
    end

endmodule

// ===== hw/rtl/pwmsv_motion.sv =====
// Move state: position, target, half period timer, step/dir levels and the moving flag.
// Computes the result of one transaction. Depends on pwmsv_pkg.
module pwmsv_motion (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_op,
    input  pwmsv_pkg::t_pos                      i_target,
    input  logic [pwmsv_pkg::HALF_PERIOD_W-1:0]  i_half_period,
    output pwmsv_pkg::t_result                   o_result
);

    pwmsv_pkg::t_pos                      r_pos, n_pos;
    pwmsv_pkg::t_pos                      r_tgt, n_tgt;
    logic [pwmsv_pkg::HALF_PERIOD_W-1:0]  r_timer, n_timer;
    logic                                 r_step, n_step;
    logic                                 r_dir, n_dir;
    logic                                 r_moving, n_moving;
    logic                                 accepted;
    logic [pwmsv_pkg::HALF_PERIOD_W-1:0]  reload;
    pwmsv_pkg::t_pos                      stepped;

    assign reload  = (i_half_period == '0) ? 16'd1 : i_half_period;
    assign stepped = r_dir ? (r_pos + 8'sd1) : (r_pos - 8'sd1);

    always_comb begin
        n_pos    = r_pos;
        n_tgt    = r_tgt;
        n_timer  = r_timer;
        n_step   = r_step;
        n_dir    = r_dir;
        n_moving = r_moving;
        accepted = 1'b0;
        if (i_op == pwmsv_pkg::OP_TICK) begin
            if (r_moving) begin
                if (r_timer > 16'd1) begin
                    n_timer = r_timer - 16'd1;
                end else if (r_step) begin
                    n_step  = 1'b0;
                    n_timer = reload;
                end else begin
                    n_pos = stepped;
                    if (stepped == r_tgt) begin
                        n_moving = 1'b0;
                        n_timer  = '0;
                    end else begin
                        n_step  = 1'b1;
                        n_timer = reload;
                    end
                end
            end
        end else if (!r_moving) begin
            accepted = 1'b1;
            n_tgt    = i_target;
            if (i_target != r_pos) begin
                n_dir    = (i_target > r_pos);
                n_moving = 1'b1;
                n_step   = 1'b1;
                n_timer  = reload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_tgt    <= '0;
            r_timer  <= '0;
            r_step   <= 1'b0;
            r_dir    <= 1'b0;
            r_moving <= 1'b0;
        end else if (i_en) begin
            r_pos    <= n_pos;
            r_tgt    <= n_tgt;
            r_timer  <= n_timer;
            r_step   <= n_step;
            r_dir    <= n_dir;
            r_moving <= n_moving;
        end
    end

    assign o_result.step_level = n_step;
    assign o_result.dir_level  = n_dir;
    assign o_result.position   = n_pos;
    assign o_result.busy_res   = n_moving;
    assign o_result.accepted   = accepted;

endmodule

// ===== hw/rtl/pwmsv_checker.sv =====
// Port-level checks for the valve positioner, and the bind that attaches them.
// Depends on pwmsv_pkg and the top level pwm_to_stepper_valve_positioner.
module pwmsv_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_valid,
    input  logic                                 i_ready,
    input  logic                                 o_step_level,
    input  logic signed [pwmsv_pkg::POS_W-1:0]   o_position,
    input  logic                                 o_busy_res,
    input  logic                                 o_accepted
);

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid after reset.");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_position) && $stable(o_busy_res))
        else $error("Stalled result changed.");

    a_idle_step_low : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_busy_res |-> !o_step_level)
        else $error("Step output high while no move is in progress.");

    a_accept_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> o_step_level == o_busy_res)
        else $error("Accepted sample did not start its move with a high step.");

    a_pos_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_position != 8'sh80)
        else $error("Position outside the valve travel.");

endmodule

bind pwm_to_stepper_valve_positioner pwmsv_checker u_pwmsv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_step_level (o_step_level),
    .o_position   (o_position),
    .o_busy_res   (o_busy_res),
    .o_accepted   (o_accepted)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for pwm_to_stepper_valve_positioner: sends tick and sample transactions,
// predicts the step, direction, position, busy and accepted flags after each one, and checks every result.
// Depends on pwmsv_pkg and the RTL of the block; nothing else.
import pwmsv_pkg::*;

class valve_tracker;
    logic [MAX_STEPS_W-1:0]   max_steps;
    logic [HALF_PERIOD_W-1:0] half_period;
    t_pos                     position;
    t_pos                     target;
    logic [HALF_PERIOD_W-1:0] half_timer;
    logic                     step_q;
    logic                     dir_q;
    logic                     moving;
    t_result                  pending_readings[$];
    int                       errors;

    function new();
        max_steps   = MAX_STEPS_RST;
        half_period = HALF_PERIOD_RST;
        position    = '0;
        target      = '0;
        half_timer  = '0;
        step_q      = 1'b0;
        dir_q       = 1'b0;
        moving      = 1'b0;
        errors      = 0;
    endfunction

    function void write_register(logic idx, logic [APB_DATA_W-1:0] value);
        case (idx)
            REG_MAX_STEPS: begin
                max_steps = value[MAX_STEPS_W-1:0];
            end
            default: begin
                half_period = value[HALF_PERIOD_W-1:0];
            end
        endcase
    endfunction

    function logic [HALF_PERIOD_W-1:0] half_reload();
        return (half_period == '0) ? 16'd1 : half_period;
    endfunction

    function void advance_tick();
        if (!moving)
            return;
        if (half_timer > 16'd1) begin
            half_timer = half_timer - 16'd1;
            return;
        end
        if (step_q) begin
            step_q     = 1'b0;
            half_timer = half_reload();
            return;
        end
        position = dir_q ? position + 8'sd1 : position - 8'sd1;
        if (position == target) begin
            moving     = 1'b0;
            half_timer = '0;
        end else begin
            step_q     = 1'b1;
            half_timer = half_reload();
        end
    endfunction

    function t_pos target_for(logic [PWM_W-1:0] heat, logic [PWM_W-1:0] cold);
        int unsigned prod;
        if (heat != '0 && cold == '0) begin
            prod = 32'(heat) * 32'(max_steps);
            return t_pos'(prod / 255);
        end
        if (cold != '0 && heat == '0) begin
            prod = 32'(cold) * 32'(max_steps);
            return -t_pos'(prod / 255);
        end
        return '0;
    endfunction

    // Returns 0 for a sample that arrives during a move, which the block ignores.
    function bit note_item(logic op, logic [PWM_W-1:0] heat, logic [PWM_W-1:0] cold);
        t_result predicted;
        bit      taken;
        taken = 1'b0;
        if (op == OP_TICK) begin
            advance_tick();
            taken = 1'b1;
        end else if (!moving) begin
            taken  = 1'b1;
            target = target_for(heat, cold);
            if (target != position) begin
                dir_q      = (target > position);
                moving     = 1'b1;
                step_q     = 1'b1;
                half_timer = half_reload();
            end
        end
        predicted.step_level = step_q;
        predicted.dir_level  = dir_q;
        predicted.position   = position;
        predicted.busy_res   = moving;
        predicted.accepted   = (op == OP_SAMPLE) && taken;
        pending_readings.push_back(predicted);
        return taken;
    endfunction

    task report_mismatch(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_result(t_result got);
        t_result want;
        if (pending_readings.size() == 0) begin
            report_mismatch($sformatf("result %h with no transaction pending", got));
            return;
        end
        want = pending_readings.pop_front();
        if (got.step_level !== want.step_level)
            report_mismatch($sformatf("step_level got %b want %b",
                                      got.step_level, want.step_level));
        if (got.dir_level !== want.dir_level)
            report_mismatch($sformatf("dir_level got %b want %b",
                                      got.dir_level, want.dir_level));
        if (got.position !== want.position)
            report_mismatch($sformatf("position got %0d want %0d",
                                      got.position, want.position));
        if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res got %b want %b",
                                      got.busy_res, want.busy_res));
        if (got.accepted !== want.accepted)
            report_mismatch($sformatf("accepted got %b want %b",
                                      got.accepted, want.accepted));
    endtask
endclass

module tb_top;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic                         i_op;
    logic [PWM_W-1:0]             i_pwm_heat;
    logic [PWM_W-1:0]             i_pwm_cold;
    logic                         o_valid;
    logic                         i_ready;
    logic                         o_step_level;
    logic                         o_dir_level;
    logic signed [POS_W-1:0]      o_position;
    logic                         o_busy_res;
    logic                         o_accepted;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [APB_ADDR_W-1:0]        paddr;
    logic [APB_DATA_W-1:0]        pwdata;
    logic [APB_DATA_W-1:0]        prdata;
    logic                         pready;

    valve_tracker valve = new();
    bit           hold_req;
    int           burst_left;

    pwm_to_stepper_valve_positioner uut (.*);

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: checks each result transaction, stalls on its own pattern, and holds off when hold_req is set.
    initial begin : receiver
        t_result got;
        int      cycle;
        int      hold_left;
        cycle     = 0;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got.step_level = o_step_level;
                got.dir_level  = o_dir_level;
                got.position   = o_position;
                got.busy_res   = o_busy_res;
                got.accepted   = o_accepted;
                valve.check_result(got);
            end
            cycle++;
            if (hold_req) begin
                hold_left = 80;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case ((cycle / 97) % 4)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= ((cycle % 7) >= 3);
                endcase
            end
        end
    end

    task automatic send_item(logic op, logic [PWM_W-1:0] heat, logic [PWM_W-1:0] cold,
                             output bit counted);
        i_valid    <= 1'b1;
        i_op       <= op;
        i_pwm_heat <= heat;
        i_pwm_cold <= cold;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        counted = valve.note_item(op, heat, cold);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic write_register(logic idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        valve.write_register(idx, value);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (valve.pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [PWM_W-1:0] pick_duty();
        case ($urandom_range(0, 5))
            0: return 8'd1;
            1: return 8'd255;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic run_random(int count, bit with_hold);
        int               done;
        int               kind;
        bit               counted;
        bit               held;
        logic             op;
        logic [PWM_W-1:0] heat;
        logic [PWM_W-1:0] cold;
        done = 0;
        held = 1'b0;
        while (done < count) begin
            pace_sender();
            op   = OP_TICK;
            heat = 8'($urandom);
            cold = 8'($urandom);
            if ($urandom_range(0, valve.moving ? 11 : 2) == 0) begin
                op   = OP_SAMPLE;
                kind = $urandom_range(0, 7);
                if (kind <= 2) begin
                    heat = pick_duty();
                    cold = '0;
                end else if (kind <= 5) begin
                    heat = '0;
                    cold = pick_duty();
                end else if (kind == 6) begin
                    heat = '0;
                    cold = '0;
                end else begin
                    heat = pick_duty();
                    cold = pick_duty();
                end
            end
            if (with_hold && !held && done >= count / 2) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            send_item(op, heat, cold, counted);
            done += counted;
        end
    endtask

    initial begin : stimulus
        bit counted;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_op       <= OP_TICK;
        i_pwm_heat <= '0;
        i_pwm_cold <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        burst_left = 0;
        hold_req   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, with samples that leave the valve where it is.
        send_item(OP_TICK, 8'hFF, 8'hFF, counted);
        send_item(OP_SAMPLE, 8'd255, 8'd255, counted);
        send_item(OP_SAMPLE, 8'd5, 8'd0, counted);
        settle();

        write_register(REG_MAX_STEPS, 32'd3);
        write_register(REG_HALF_PERIOD, 32'd1);
        send_item(OP_SAMPLE, 8'd255, 8'd0, counted);
        send_item(OP_SAMPLE, 8'd0, 8'd255, counted);
        repeat (6) send_item(OP_TICK, 8'($urandom), 8'($urandom), counted);
        send_item(OP_SAMPLE, 8'd255, 8'd0, counted);
        send_item(OP_SAMPLE, 8'd0, 8'd170, counted);
        repeat (10) send_item(OP_TICK, 8'($urandom), 8'($urandom), counted);
        send_item(OP_SAMPLE, 8'd128, 8'd128, counted);
        repeat (4) send_item(OP_TICK, 8'($urandom), 8'($urandom), counted);
        send_item(OP_SAMPLE, 8'd0, 8'd0, counted);
        send_item(OP_TICK, 8'd0, 8'd0, counted);
        settle();

        write_register(REG_MAX_STEPS, 32'd127);
        write_register(REG_HALF_PERIOD, 32'd1);
        run_random(130, 1'b1);
        settle();

        write_register(REG_MAX_STEPS, 32'd1);
        write_register(REG_HALF_PERIOD, 32'd2);
        run_random(110, 1'b0);
        settle();

        write_register(REG_MAX_STEPS, 32'hFFFF_FF80);
        write_register(REG_HALF_PERIOD, 32'hABCD_0000);
        run_random(70, 1'b0);
        settle();

        write_register(REG_MAX_STEPS, 32'($urandom_range(1, 127)));
        write_register(REG_HALF_PERIOD, 32'($urandom_range(1, 4)));
        run_random(140, 1'b1);
        settle();

        write_register(REG_MAX_STEPS, ($urandom & 32'hFFFF_FF80) | $urandom_range(1, 127));
        write_register(REG_HALF_PERIOD, ($urandom & 32'hFFFF_0000) | 32'd3);
        run_random(120, 1'b0);
        settle();

        write_register(REG_MAX_STEPS, 32'd127);
        write_register(REG_HALF_PERIOD, 32'd65535);
        run_random(40, 1'b0);
        settle();
        repeat (10) @(posedge i_clk);

        if (valve.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pwmsv_pkg.sv
hw/rtl/pwmsv_target.sv
hw/rtl/pwmsv_motion.sv
hw/rtl/pwm_to_stepper_valve_positioner.sv
hw/rtl/pwmsv_checker.sv
sim/tb_top.sv
